/* hdl/msfc_pkg.sv */
// Shared types, constants and the coefficient table of the motor speed filter and controller.
package msfc_pkg;

    localparam int SPEED_WIDTH  = 24;
    localparam int HIST_DEPTH   = 5;
    localparam int DRIVE_WIDTH  = 16;
    localparam int LIMIT_WIDTH  = 15;
    localparam int PWM_WIDTH    = 16;
    localparam int DIR_WIDTH    = 2;
    localparam int COEF_WIDTH   = 21;
    localparam int DIGIT_WIDTH  = 4;
    localparam int ACC_WIDTH    = SPEED_WIDTH + 24;
    localparam int U_WIDTH      = ACC_WIDTH - 17;
    localparam int TERM_WIDTH   = 4;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = SPEED_WIDTH;
    localparam int IN_DATA_WIDTH  = ((SPEED_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS_WIDTH = SPEED_WIDTH + DRIVE_WIDTH + PWM_WIDTH + DIR_WIDTH;
    localparam int OUT_DATA_WIDTH = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int PWM_T_WIDTH  = 21;
    localparam int PWM_R_WIDTH  = 22;
    localparam int PWM_SHIFT    = 26;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TARGET_SPEED = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DRIVE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEAD_ZONE    = 2'd2;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET     = 15'd17920;
    localparam logic [LIMIT_WIDTH-1:0] DEAD_ZONE_RESET = 15'd768;
    localparam logic [LIMIT_WIDTH-1:0] FULL_SCALE      = 15'd25600;
    localparam logic [DRIVE_WIDTH-1:0] STOP_BAND       = 16'd512;

    // Noise gates: values strictly inside these bounds are treated as zero.
    localparam logic signed [SPEED_WIDTH-1:0] RAW_GATE   = SPEED_WIDTH'(128);
    localparam logic signed [SPEED_WIDTH-1:0] FILT_GATE  = SPEED_WIDTH'(52);
    localparam logic signed [SPEED_WIDTH-1:0] SETPT_GATE = SPEED_WIDTH'(26);

    // Rounding offsets preloaded into the accumulator.
    localparam logic signed [ACC_WIDTH-1:0] FILT_ROUND = ACC_WIDTH'(32768);
    localparam logic signed [ACC_WIDTH-1:0] CTRL_ROUND = ACC_WIDTH'(65536);

    // Reciprocal of 25: floor(t / 25) == (t * PWM_RECIP) >> 26 for t below 2^21.
    localparam logic [PWM_R_WIDTH-1:0] PWM_RECIP = 22'd2684355;

    localparam logic [DIR_WIDTH-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_WIDTH-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_WIDTH-1:0] DIR_REVERSE = 2'd2;

    // Product terms, in the order the sequencer steps through them.
    localparam logic [TERM_WIDTH-1:0] TERM_RAW     = 4'd0;
    localparam logic [TERM_WIDTH-1:0] TERM_FILTER  = 4'd1;
    localparam logic [TERM_WIDTH-1:0] TERM_SETPT   = 4'd2;
    localparam logic [TERM_WIDTH-1:0] TERM_SPEED   = 4'd3;
    localparam logic [TERM_WIDTH-1:0] TERM_PREV    = 4'd4;
    localparam logic [TERM_WIDTH-1:0] TERM_HIST0   = 4'd5;
    localparam logic [TERM_WIDTH-1:0] TERM_HIST1   = 4'd6;
    localparam logic [TERM_WIDTH-1:0] TERM_HIST2   = 4'd7;
    localparam logic [TERM_WIDTH-1:0] TERM_HIST3   = 4'd8;
    localparam logic [TERM_WIDTH-1:0] TERM_HIST4   = 4'd9;

    typedef struct packed {
        logic                  neg;
        logic [COEF_WIDTH-1:0] mag;
    } coef_t;

    typedef struct packed {
        logic                  start;
        logic                  init;
        logic                  neg;
        logic [COEF_WIDTH-1:0] coef;
    } mac_cmd_t;

    typedef struct packed {
        logic signed [DRIVE_WIDTH-1:0] hist;
        logic signed [DRIVE_WIDTH-1:0] drive;
        logic [LIMIT_WIDTH-1:0]        mag;
    } drive_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ISSUE = 8'b0000_0010,
        S_WAIT  = 8'b0000_0100,
        S_FILT  = 8'b0000_1000,
        S_SHAPE = 8'b0001_0000,
        S_PWM   = 8'b0010_0000,
        S_OUT   = 8'b0100_0000
    } state_t;

    // Q.16 coefficients; history coefficients are doubled so that all
    // controller terms share one rounding at bit 17.
    function automatic coef_t term_coef(input logic [TERM_WIDTH-1:0] idx);
        coef_t c;
        c.neg = 1'b0;
        c.mag = '0;
        case (idx)
            TERM_RAW:    begin c.neg = 1'b0; c.mag = 21'd9830;    end
            TERM_FILTER: begin c.neg = 1'b0; c.mag = 21'd55706;   end
            TERM_SETPT:  begin c.neg = 1'b0; c.mag = 21'd90807;   end
            TERM_SPEED:  begin c.neg = 1'b1; c.mag = 21'd1060761; end
            TERM_PREV:   begin c.neg = 1'b0; c.mag = 21'd969954;  end
            TERM_HIST0:  begin c.neg = 1'b1; c.mag = 21'd1106;    end
            TERM_HIST1:  begin c.neg = 1'b1; c.mag = 21'd1018;    end
            TERM_HIST2:  begin c.neg = 1'b1; c.mag = 21'd936;     end
            TERM_HIST3:  begin c.neg = 1'b0; c.mag = 21'd68938;   end
            TERM_HIST4:  begin c.neg = 1'b0; c.mag = 21'd67290;   end
            default:     begin c.neg = 1'b0; c.mag = '0;          end
        endcase
        return c;
    endfunction

endpackage

/* hdl/msfc_digit_mac.sv */
// Digit-serial multiply-accumulate unit: four coefficient bits per cycle.
module msfc_digit_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  msfc_pkg::mac_cmd_t                     cmd,
    input  logic signed [msfc_pkg::SPEED_WIDTH-1:0] operand,
    input  logic signed [msfc_pkg::ACC_WIDTH-1:0]   acc_init,
    output logic                                   busy,
    output logic signed [msfc_pkg::ACC_WIDTH-1:0]   acc
);

    logic signed [msfc_pkg::ACC_WIDTH-1:0]  acc_reg, acc_next;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]  op_reg, op_next;
    logic [msfc_pkg::COEF_WIDTH-1:0]        coef_reg, coef_next;
    logic                                   busy_reg, busy_next;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]  op_ext;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]  digit_ext;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]  partial;
    logic [msfc_pkg::COEF_WIDTH-1:0]        coef_shift;

    assign op_ext = {{(msfc_pkg::ACC_WIDTH - msfc_pkg::SPEED_WIDTH){operand[msfc_pkg::SPEED_WIDTH-1]}},
                     operand};
    assign digit_ext = $signed({{(msfc_pkg::ACC_WIDTH - msfc_pkg::DIGIT_WIDTH){1'b0}},
                                coef_reg[msfc_pkg::DIGIT_WIDTH-1:0]});
    assign partial    = op_reg * digit_ext;
    assign coef_shift = coef_reg >> msfc_pkg::DIGIT_WIDTH;

    always_comb
    begin
        acc_next  = acc_reg;
        op_next   = op_reg;
        coef_next = coef_reg;
        busy_next = busy_reg;
        if (cmd.init)
        begin
            acc_next = acc_init;
        end
        if (cmd.start)
        begin
            // The sign of the coefficient is folded into the operand.
            op_next   = cmd.neg ? -op_ext : op_ext;
            coef_next = cmd.coef;
            busy_next = (cmd.coef != '0);
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + partial;
            op_next   = op_reg <<< msfc_pkg::DIGIT_WIDTH;
            coef_next = coef_shift;
            busy_next = (coef_shift != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        op_reg   <= op_next;
        coef_reg <= coef_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

/* hdl/msfc_drive_shaper.sv */
// Dead zone, clamp and stop band applied to the rounded controller output.
module msfc_drive_shaper (
    input  logic signed [msfc_pkg::U_WIDTH-1:0]  u,
    input  logic [msfc_pkg::LIMIT_WIDTH-1:0]     drive_limit,
    input  logic [msfc_pkg::LIMIT_WIDTH-1:0]     drive_dead_zone,
    output msfc_pkg::drive_t                     result
);

    logic signed [msfc_pkg::U_WIDTH-1:0]     u_mag;
    logic signed [msfc_pkg::U_WIDTH-1:0]     u_dz;
    logic signed [msfc_pkg::U_WIDTH-1:0]     lim_pos;
    logic signed [msfc_pkg::U_WIDTH-1:0]     lim_neg;
    logic signed [msfc_pkg::U_WIDTH-1:0]     u_clamp;
    logic [msfc_pkg::U_WIDTH-1:0]            dz_ext;
    logic [msfc_pkg::LIMIT_WIDTH-1:0]        lim;
    logic signed [msfc_pkg::DRIVE_WIDTH-1:0] hist;
    logic [msfc_pkg::DRIVE_WIDTH-1:0]        hist_mag;

    always_comb
    begin
        u_mag  = u[msfc_pkg::U_WIDTH-1] ? -u : u;
        dz_ext = {{(msfc_pkg::U_WIDTH - msfc_pkg::LIMIT_WIDTH){1'b0}}, drive_dead_zone};
        u_dz   = ($unsigned(u_mag) < dz_ext) ? '0 : u;

        lim     = (drive_limit > msfc_pkg::FULL_SCALE) ? msfc_pkg::FULL_SCALE : drive_limit;
        lim_pos = $signed({{(msfc_pkg::U_WIDTH - msfc_pkg::LIMIT_WIDTH){1'b0}}, lim});
        lim_neg = -lim_pos;

        if (u_dz > lim_pos)
        begin
            u_clamp = lim_pos;
        end
        else if (u_dz < lim_neg)
        begin
            u_clamp = lim_neg;
        end
        else
        begin
            u_clamp = u_dz;
        end

        hist     = u_clamp[msfc_pkg::DRIVE_WIDTH-1:0];
        hist_mag = hist[msfc_pkg::DRIVE_WIDTH-1] ? $unsigned(-hist) : $unsigned(hist);

        result.hist = hist;
        if (hist_mag < msfc_pkg::STOP_BAND)
        begin
            result.drive = '0;
            result.mag   = '0;
        end
        else
        begin
            result.drive = hist;
            result.mag   = hist_mag[msfc_pkg::LIMIT_WIDTH-1:0];
        end
    end

endmodule

/* hdl/motor_speed_filter_and_controller.sv */
// Top level of the motor speed filter and controller: sequencer, state and stream ports.
//
// Each accepted item is one control tick carrying a raw speed sample (signed rpm,
// 8 fraction bits). The block gates out samples below 0.5 rpm, runs a first-order
// low-pass filter (alpha 0.15), gates filtered values below 0.2 rpm, and then
// evaluates a fixed difference-equation controller from the setpoint, the
// filtered speed, its previous value and the last five drive levels. The drive
// gets a dead zone and a clamp and is returned with a direction code and a
// 16-bit PWM level; exactly one result item comes out per input item. All ten
// products go through one shared multiply-accumulate unit that consumes four
// coefficient bits per cycle, and that unit sets the rate. The next item is
// accepted only once the result of the previous one has been placed in the output
// register. When the setpoint magnitude is below 0.1 rpm the drive is zero and the
// controller history is cleared, while the filter keeps running and the
// controller products are skipped. A new item is taken while the previous result
// still waits in the output register; a result held there until the next result
// is ready stalls the sequencer and the input.
// Configuration registers should only be written while no item is in flight.
module motor_speed_filter_and_controller (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration write port.
    input  logic                                    cfg_write,
    input  logic [msfc_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [msfc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // Input item stream.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [msfc_pkg::IN_DATA_WIDTH-1:0]      s_axis_tdata,   // raw_speed
    // Result item stream.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [msfc_pkg::OUT_DATA_WIDTH-1:0]     m_axis_tdata    // filtered_speed,
                                                                    // drive_percent,
                                                                    // pwm_level, direction
);

    localparam int SW = msfc_pkg::SPEED_WIDTH;
    localparam int DW = msfc_pkg::DRIVE_WIDTH;

    msfc_pkg::state_t                         state_reg, state_next;
    logic [msfc_pkg::TERM_WIDTH-1:0]          term_reg, term_next;

    logic signed [SW-1:0]                     target_reg;
    logic [msfc_pkg::LIMIT_WIDTH-1:0]         limit_reg;
    logic [msfc_pkg::LIMIT_WIDTH-1:0]         dead_zone_reg;

    logic signed [SW-1:0]                     x_reg, x_next;
    logic signed [SW-1:0]                     filter_value_reg, filter_value_next;
    logic signed [SW-1:0]                     prev_reg, prev_next;
    logic signed [DW-1:0]                     hist_reg [msfc_pkg::HIST_DEPTH];
    logic signed [DW-1:0]                     hist_next [msfc_pkg::HIST_DEPTH];
    logic signed [DW-1:0]                     drive_reg, drive_next;
    logic [msfc_pkg::LIMIT_WIDTH-1:0]         mag_reg, mag_next;
    logic [msfc_pkg::PWM_WIDTH-1:0]           pwm_reg, pwm_next;

    logic                                     out_valid_reg, out_valid_next;
    logic [msfc_pkg::OUT_DATA_WIDTH-1:0]      out_data_reg, out_data_next;

    msfc_pkg::mac_cmd_t                       mac_cmd;
    msfc_pkg::coef_t                          coef;
    logic signed [SW-1:0]                     mac_operand;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]    mac_init;
    logic                                     mac_busy;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]    mac_acc;

    msfc_pkg::drive_t                         shaped;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]    filt_shift;
    logic signed [msfc_pkg::ACC_WIDTH-1:0]    ctrl_shift;
    logic signed [SW-1:0]                     filt_val;
    logic signed [SW-1:0]                     raw_in;
    logic                                     in_accept;
    logic                                     out_free;
    logic                                     setpoint_small;
    logic [msfc_pkg::LIMIT_WIDTH+15:0]        pwm_scaled;
    logic [msfc_pkg::PWM_T_WIDTH-1:0]         pwm_t;
    logic [msfc_pkg::PWM_T_WIDTH+msfc_pkg::PWM_R_WIDTH-1:0] pwm_prod;
    logic [msfc_pkg::DIR_WIDTH-1:0]           dir;

    assign raw_in        = s_axis_tdata[SW-1:0];
    assign s_axis_tready = (state_reg == msfc_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            limit_reg     <= msfc_pkg::LIMIT_RESET;
            dead_zone_reg <= msfc_pkg::DEAD_ZONE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                msfc_pkg::CFG_TARGET_SPEED: target_reg    <= cfg_data[SW-1:0];
                msfc_pkg::CFG_DRIVE_LIMIT:  limit_reg     <= cfg_data[msfc_pkg::LIMIT_WIDTH-1:0];
                msfc_pkg::CFG_DEAD_ZONE:    dead_zone_reg <= cfg_data[msfc_pkg::LIMIT_WIDTH-1:0];
                default:                    target_reg    <= target_reg;
            endcase
        end
    end

    // Operand for the product term being issued.
    always_comb
    begin
        case (term_reg)
            msfc_pkg::TERM_RAW:    mac_operand = x_reg;
            msfc_pkg::TERM_FILTER: mac_operand = filter_value_reg;
            msfc_pkg::TERM_SETPT:  mac_operand = target_reg;
            msfc_pkg::TERM_SPEED:  mac_operand = filter_value_reg;
            msfc_pkg::TERM_PREV:   mac_operand = prev_reg;
            msfc_pkg::TERM_HIST0:  mac_operand = SW'(hist_reg[0]);
            msfc_pkg::TERM_HIST1:  mac_operand = SW'(hist_reg[1]);
            msfc_pkg::TERM_HIST2:  mac_operand = SW'(hist_reg[2]);
            msfc_pkg::TERM_HIST3:  mac_operand = SW'(hist_reg[3]);
            msfc_pkg::TERM_HIST4:  mac_operand = SW'(hist_reg[4]);
            default:               mac_operand = '0;
        endcase
    end

    assign coef = msfc_pkg::term_coef(term_reg);

    msfc_digit_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mac_cmd),
        .operand  (mac_operand),
        .acc_init (mac_init),
        .busy     (mac_busy),
        .acc      (mac_acc)
    );

    // The accumulator is preloaded with half an output LSB, so rounding is a plain shift.
    assign filt_shift = mac_acc >>> 16;
    assign ctrl_shift = mac_acc >>> 17;
    assign filt_val   = filt_shift[SW-1:0];

    msfc_drive_shaper u_shaper (
        .u               (ctrl_shift[msfc_pkg::U_WIDTH-1:0]),
        .drive_limit     (limit_reg),
        .drive_dead_zone (dead_zone_reg),
        .result          (shaped)
    );

    assign setpoint_small = (target_reg > -msfc_pkg::SETPT_GATE)
                         && (target_reg < msfc_pkg::SETPT_GATE);

    // PWM level is |drive| * 65535 / 25600: the scaling by 65535 is a shift and
    // subtract, the division by 1024 a shift, and the division by 25 a reciprocal.
    assign pwm_scaled = {mag_reg, 16'b0} - {16'b0, mag_reg};
    assign pwm_t      = pwm_scaled[msfc_pkg::PWM_T_WIDTH+9:10];
    assign pwm_prod   = {{msfc_pkg::PWM_R_WIDTH{1'b0}}, pwm_t}
                      * {{msfc_pkg::PWM_T_WIDTH{1'b0}}, msfc_pkg::PWM_RECIP};

    always_comb
    begin
        if (drive_reg > 0)
        begin
            dir = msfc_pkg::DIR_FORWARD;
        end
        else if (drive_reg < 0)
        begin
            dir = msfc_pkg::DIR_REVERSE;
        end
        else
        begin
            dir = msfc_pkg::DIR_STOP;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        term_next         = term_reg;
        x_next            = x_reg;
        filter_value_next = filter_value_reg;
        prev_next         = prev_reg;
        hist_next         = hist_reg;
        drive_next        = drive_reg;
        mag_next          = mag_reg;
        pwm_next          = pwm_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;
        mac_cmd.start     = 1'b0;
        mac_cmd.init      = 1'b0;
        mac_cmd.neg       = coef.neg;
        mac_cmd.coef      = coef.mag;
        mac_init          = msfc_pkg::FILT_ROUND;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            msfc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    // Samples below 0.5 rpm in magnitude are noise.
                    if ((raw_in > -msfc_pkg::RAW_GATE) && (raw_in < msfc_pkg::RAW_GATE))
                    begin
                        x_next = '0;
                    end
                    else
                    begin
                        x_next = raw_in;
                    end
                    mac_cmd.init = 1'b1;
                    mac_init     = msfc_pkg::FILT_ROUND;
                    term_next    = msfc_pkg::TERM_RAW;
                    state_next   = msfc_pkg::S_ISSUE;
                end
            end
            msfc_pkg::S_ISSUE:
            begin
                mac_cmd.start = 1'b1;
                state_next    = msfc_pkg::S_WAIT;
            end
            msfc_pkg::S_WAIT:
            begin
                if (!mac_busy)
                begin
                    if (term_reg == msfc_pkg::TERM_FILTER)
                    begin
                        state_next = msfc_pkg::S_FILT;
                    end
                    else if (term_reg == msfc_pkg::TERM_HIST4)
                    begin
                        state_next = msfc_pkg::S_SHAPE;
                    end
                    else
                    begin
                        term_next  = term_reg + {{(msfc_pkg::TERM_WIDTH-1){1'b0}}, 1'b1};
                        state_next = msfc_pkg::S_ISSUE;
                    end
                end
            end
            msfc_pkg::S_FILT:
            begin
                if ((filt_val > -msfc_pkg::FILT_GATE) && (filt_val < msfc_pkg::FILT_GATE))
                begin
                    filter_value_next = '0;
                end
                else
                begin
                    filter_value_next = filt_val;
                end
                if (setpoint_small)
                begin
                    prev_next = '0;
                    for (int i = 0; i < msfc_pkg::HIST_DEPTH; i++)
                    begin
                        hist_next[i] = '0;
                    end
                    drive_next = '0;
                    mag_next   = '0;
                    state_next = msfc_pkg::S_PWM;
                end
                else
                begin
                    mac_cmd.init = 1'b1;
                    mac_init     = msfc_pkg::CTRL_ROUND;
                    term_next    = msfc_pkg::TERM_SETPT;
                    state_next   = msfc_pkg::S_ISSUE;
                end
            end
            msfc_pkg::S_SHAPE:
            begin
                prev_next    = filter_value_reg;
                hist_next[0] = shaped.hist;
                for (int i = 1; i < msfc_pkg::HIST_DEPTH; i++)
                begin
                    hist_next[i] = hist_reg[i-1];
                end
                drive_next = shaped.drive;
                mag_next   = shaped.mag;
                state_next = msfc_pkg::S_PWM;
            end
            msfc_pkg::S_PWM:
            begin
                pwm_next   = pwm_prod[msfc_pkg::PWM_SHIFT+msfc_pkg::PWM_WIDTH-1:msfc_pkg::PWM_SHIFT];
                state_next = msfc_pkg::S_OUT;
            end
            msfc_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(msfc_pkg::OUT_DATA_WIDTH - msfc_pkg::OUT_FIELDS_WIDTH){1'b0}},
                                      dir, pwm_reg, drive_reg, filter_value_reg};
                    state_next     = msfc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = msfc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= msfc_pkg::S_IDLE;
            term_reg         <= msfc_pkg::TERM_RAW;
            filter_value_reg <= '0;
            prev_reg         <= '0;
            for (int i = 0; i < msfc_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            term_reg         <= term_next;
            filter_value_reg <= filter_value_next;
            prev_reg         <= prev_next;
            hist_reg         <= hist_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        drive_reg    <= drive_next;
        mag_reg      <= mag_next;
        pwm_reg      <= pwm_next;
        out_data_reg <= out_data_next;
    end

    // The shared multiplier only runs while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_busy |-> (state_reg == msfc_pkg::S_WAIT))
        else $error("digit multiplier busy outside of the wait state");

    // After the filter update the stored value is either zero or outside the gate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msfc_pkg::S_FILT) |=>
            (filter_value_reg == '0) || (filter_value_reg >= msfc_pkg::FILT_GATE)
            || (filter_value_reg <= -msfc_pkg::FILT_GATE))
        else $error("filtered value inside the noise gate was kept");

    // Stored drive levels never exceed full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hist_reg[0] <= $signed({1'b0, msfc_pkg::FULL_SCALE}))
        && (hist_reg[0] >= -$signed({1'b0, msfc_pkg::FULL_SCALE})))
        else $error("drive history entry beyond full scale");

    // A result that says stop carries no drive and no PWM level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[SW+DW+msfc_pkg::PWM_WIDTH+:msfc_pkg::DIR_WIDTH]
                           == msfc_pkg::DIR_STOP))
        |-> (out_data_reg[SW+:DW+msfc_pkg::PWM_WIDTH] == '0))
        else $error("stop direction with nonzero drive or PWM level");

endmodule

/* dv/motor_speed_filter_and_controller_tb.sv */
// Self-checking testbench for the motor speed filter and controller, with its own bit-exact predictor.
`timescale 1ns / 1ps

module motor_speed_filter_and_controller_tb;

    localparam int SW = msfc_pkg::SPEED_WIDTH;
    localparam int LW = msfc_pkg::LIMIT_WIDTH;

    // Cycles without any accepted item before the run is declared hung. The slowest
    // legitimate quiet stretch is the long receiver hold-off plus two item times.
    localparam int WATCHDOG_LIMIT = 4000;
    // Length of the deliberate receiver hold-off that backs the block up.
    localparam int STALL_CYCLES   = 400;
    // Cycles to keep watching after the last result, well above one item time.
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 95;

    localparam logic signed [SW-1:0] SPEED_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SPEED_MIN = {1'b1, {(SW-1){1'b0}}};

    // One result item, laid out as on m_axis_tdata: last field in the lowest bits.
    typedef struct packed {
        logic [msfc_pkg::DIR_WIDTH-1:0]          dir;
        logic [msfc_pkg::PWM_WIDTH-1:0]          pwm;
        logic signed [msfc_pkg::DRIVE_WIDTH-1:0] drive;
        logic signed [SW-1:0]                    filt;
    } tick_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_write = 1'b0;
    logic [msfc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index = '0;
    logic [msfc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                                 s_tvalid = 1'b0;
    logic [msfc_pkg::IN_DATA_WIDTH-1:0]   s_tdata = '0;
    logic                                 s_axis_tready;
    logic                                 m_axis_tvalid;
    logic                                 m_tready = 1'b0;
    logic [msfc_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata;

    // When set, neither side inserts random idle cycles.
    bit steady = 1'b0;
    // Raised by a test, picked up and cleared by the result receiver.
    bit stall_request = 1'b0;

    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Results predicted for accepted samples, oldest first.
    tick_result_t pending_ticks[$];

    // Predictor copy of the registers, at their reset values.
    logic signed [SW-1:0] set_speed = '0;
    logic [LW-1:0]        limit_reg = msfc_pkg::LIMIT_RESET;
    logic [LW-1:0]        dz_reg    = msfc_pkg::DEAD_ZONE_RESET;

    // Predictor copy of the filter and controller state; entry 0 is the newest drive.
    longint filt_state = 0;
    longint prev_speed = 0;
    longint drive_hist[msfc_pkg::HIST_DEPTH] = '{default: 0};

    always #1 clk = ~clk;

    motor_speed_filter_and_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Computes one control tick exactly as the hardware should: noise gate, low-pass
    // filter with one rounding at bit 16, second gate, then the difference equation
    // summed in 64 bits and rounded once at bit 17 (history terms are doubled to
    // share that rounding). Arithmetic right shifts of the biased sum give the
    // round-half-up behavior for negative values too.
    function automatic tick_result_t control_tick(input logic signed [SW-1:0] raw);
        longint       x;
        longint       sp;
        longint       f;
        longint       acc;
        longint       poly;
        longint       u;
        longint       lim;
        longint       mag;
        longint       drive_q;
        tick_result_t r;
        int           i;
        x = longint'(raw);
        if (x > -128 && x < 128)
            x = 0;
        f = (9830 * x + 55706 * filt_state + 32768) >>> 16;
        if (f > -52 && f < 52)
            f = 0;
        filt_state = f;

        sp = longint'(set_speed);
        drive_q = 0;
        if (sp > -26 && sp < 26) begin
            // Setpoint too small to act on: controller memory is wiped.
            prev_speed = 0;
            for (i = 0; i < msfc_pkg::HIST_DEPTH; i++)
                drive_hist[i] = 0;
        end
        else begin
            lim = longint'(limit_reg);
            if (lim > 25600)
                lim = 25600;
            acc = 90807 * sp - (1060761 * f - 969954 * prev_speed);
            poly = -553 * drive_hist[0] - 509 * drive_hist[1] - 468 * drive_hist[2]
                   + 34469 * drive_hist[3] + 33645 * drive_hist[4];
            u = (acc + 2 * poly + 65536) >>> 17;
            mag = (u < 0) ? -u : u;
            if (mag < longint'(dz_reg))
                u = 0;
            if (u > lim)
                u = lim;
            else if (u < -lim)
                u = -lim;
            prev_speed = f;
            for (i = msfc_pkg::HIST_DEPTH - 1; i > 0; i--)
                drive_hist[i] = drive_hist[i - 1];
            drive_hist[0] = u;
            // The stored value keeps its size; only the reported drive is banded.
            drive_q = u;
            if (((u < 0) ? -u : u) < 512)
                drive_q = 0;
        end

        mag = (drive_q < 0) ? -drive_q : drive_q;
        r.filt  = f[SW-1:0];
        r.drive = drive_q[msfc_pkg::DRIVE_WIDTH-1:0];
        r.pwm   = msfc_pkg::PWM_WIDTH'((mag * 65535) / 25600);
        if (drive_q > 0)
            r.dir = msfc_pkg::DIR_FORWARD;
        else if (drive_q < 0)
            r.dir = msfc_pkg::DIR_REVERSE;
        else
            r.dir = msfc_pkg::DIR_STOP;
        return r;
    endfunction

    // Writes one register and mirrors it into the predictor. Only called while
    // nothing is in flight.
    task automatic write_register(input logic [msfc_pkg::CFG_IDX_WIDTH-1:0] idx,
                                  input logic [msfc_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            msfc_pkg::CFG_TARGET_SPEED: set_speed = data[SW-1:0];
            msfc_pkg::CFG_DRIVE_LIMIT:  limit_reg = data[LW-1:0];
            msfc_pkg::CFG_DEAD_ZONE:    dz_reg    = data[LW-1:0];
            default:                    ;
        endcase
        @(posedge clk);
    endtask

    // Offers one speed sample, now and then after an idle gap of random length so
    // that gaps land on every phase of the block's sequencer. The valid is left high
    // on return; the next send or the drain decides its next value.
    task automatic send_sample(input logic signed [SW-1:0] raw);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 6)
            gap = $urandom_range(1, 90);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_ticks.insert(pending_ticks.size(), control_tick(raw));
    endtask

    // Stops offering and waits until every predicted result has been checked.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Default registers, setpoint zero: only the two noise gates and the filter act.
    // Covers the raw gate edges, the filter gate on decay and both full-scale samples.
    task automatic test_noise_gates();
        send_sample(0);
        send_sample(127);
        send_sample(-127);
        send_sample(128);
        send_sample(-128);
        send_sample(400);
        send_sample(0);
        send_sample(-400);
        send_sample(0);
        send_sample(SPEED_MAX);
        send_sample(SPEED_MIN);
        send_sample(0);
        wait_for_results();
    endtask

    // Setpoint magnitudes on both sides of the small-setpoint gate, both signs.
    task automatic test_setpoint_gate();
        write_register(msfc_pkg::CFG_TARGET_SPEED, 24'sd25);
        send_sample(1000);
        wait_for_results();
        write_register(msfc_pkg::CFG_TARGET_SPEED, -24'sd26);
        send_sample(1000);
        send_sample(-1000);
        wait_for_results();
        write_register(msfc_pkg::CFG_TARGET_SPEED, 24'sd26);
        send_sample(0);
        wait_for_results();
        write_register(msfc_pkg::CFG_TARGET_SPEED, -24'sd25);
        send_sample(500);
        wait_for_results();
    endtask

    // Dead zone, clamp, a limit beyond full scale and the final stop band.
    task automatic test_drive_shaping();
        write_register(msfc_pkg::CFG_DRIVE_LIMIT, 24'h007FFF);
        write_register(msfc_pkg::CFG_DEAD_ZONE, 24'd0);
        write_register(msfc_pkg::CFG_TARGET_SPEED, 24'h7FFFFF);
        send_sample(SPEED_MIN);
        send_sample(0);
        wait_for_results();
        write_register(msfc_pkg::CFG_TARGET_SPEED, 24'h800000);
        send_sample(SPEED_MAX);
        wait_for_results();
        // A clamp below the stop band: the drive is stored but reported as zero.
        write_register(msfc_pkg::CFG_DRIVE_LIMIT, 24'd300);
        write_register(msfc_pkg::CFG_TARGET_SPEED, 24'd25600);
        send_sample(0);
        send_sample(0);
        wait_for_results();
        write_register(msfc_pkg::CFG_DRIVE_LIMIT, 24'd25600);
        write_register(msfc_pkg::CFG_DEAD_ZONE, 24'd25600);
        send_sample(0);
        send_sample(25600);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while samples keep coming, so the
    // output register and the sequencer both fill and the input stalls.
    task automatic test_output_backpressure();
        int i;
        write_register(msfc_pkg::CFG_DEAD_ZONE, 24'd768);
        write_register(msfc_pkg::CFG_DRIVE_LIMIT, 24'd17920);
        write_register(msfc_pkg::CFG_TARGET_SPEED, 24'd256000);
        stall_request = 1'b1;
        for (i = 0; i < 8; i++)
            send_sample(24'd250000 + 24'($urandom_range(0, 8000)));
        wait_for_results();
    endtask

    // Random phases: each picks a register setting (extremes included, with random
    // bits above the register width) and then mostly sends samples that track the
    // setpoint, so the filter and the drive history stay in the working range, mixed
    // with samples around the gate, fully random words and full-scale values.
    task automatic test_random_ticks();
        int     p;
        int     i;
        int     kind;
        longint sp;
        longint v;
        longint spread;
        logic [LW-1:0] reg_val;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            steady = (p == 4);
            case ($urandom_range(9))
                0:       sp = longint'($urandom_range(0, 60)) - 30;
                1:       sp = longint'(SPEED_MAX);
                2:       sp = longint'(SPEED_MIN);
                default:
                begin
                    sp = longint'($urandom_range(26, 2000000));
                    if ($urandom_range(1))
                        sp = -sp;
                end
            endcase
            write_register(msfc_pkg::CFG_TARGET_SPEED, sp[SW-1:0]);

            case ($urandom_range(5))
                0:       reg_val = '0;
                1:       reg_val = msfc_pkg::FULL_SCALE;
                2:       reg_val = '1;
                default: reg_val = LW'($urandom_range(0, 25600));
            endcase
            write_register(msfc_pkg::CFG_DRIVE_LIMIT, {9'($urandom), reg_val});

            case ($urandom_range(9))
                0:       reg_val = '0;
                1:       reg_val = msfc_pkg::FULL_SCALE;
                2:       reg_val = '1;
                default: reg_val = LW'($urandom_range(0, 2000));
            endcase
            write_register(msfc_pkg::CFG_DEAD_ZONE, {9'($urandom), reg_val});

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                kind = $urandom_range(99);
                if (kind < 65)
                begin
                    case ($urandom_range(3))
                        0:       spread = 16;
                        1:       spread = 256;
                        2:       spread = 4096;
                        default: spread = 65536;
                    endcase
                    v = sp + longint'($urandom_range(0, 2 * spread)) - spread;
                    if (v > longint'(SPEED_MAX))
                        v = longint'(SPEED_MAX);
                    if (v < longint'(SPEED_MIN))
                        v = longint'(SPEED_MIN);
                end
                else if (kind < 80)
                    v = longint'($urandom_range(0, 400)) - 200;
                else if (kind < 90)
                    v = longint'($signed(SW'($urandom)));
                else
                    v = $urandom_range(1) ? longint'(SPEED_MAX) : longint'(SPEED_MIN);
                send_sample(v[SW-1:0]);
            end
            // The sender pauses here until every result of the phase is back.
            wait_for_results();
        end
        steady = 1'b0;
    endtask

    // Result receiver: random ready, a long hold-off on request, none while steady.
    initial
    begin : result_receiver
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // Compares every accepted result with the oldest prediction, field by field.
    always @(posedge clk)
    begin : result_checker
        tick_result_t got;
        tick_result_t want;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            got = m_axis_tdata[msfc_pkg::OUT_FIELDS_WIDTH-1:0];
            if (pending_ticks.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = pending_ticks.pop_front();
                if (got.filt !== want.filt)
                begin
                    mismatch_count++;
                    $display("%0t ns: filtered_speed expected %0d, actual %0d",
                             $time, want.filt, got.filt);
                end
                if (got.drive !== want.drive)
                begin
                    mismatch_count++;
                    $display("%0t ns: drive_percent expected %0d, actual %0d",
                             $time, want.drive, got.drive);
                end
                if (got.pwm !== want.pwm)
                begin
                    mismatch_count++;
                    $display("%0t ns: pwm_level expected %0d, actual %0d",
                             $time, want.pwm, got.pwm);
                end
                if (got.dir !== want.dir)
                begin
                    mismatch_count++;
                    $display("%0t ns: direction expected %0d, actual %0d",
                             $time, want.dir, got.dir);
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither stream moves an item.
    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : test_sequence
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_noise_gates();
        test_setpoint_gate();
        test_drive_shaping();
        test_output_backpressure();
        test_random_ticks();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/msfc_pkg.sv
hdl/msfc_digit_mac.sv
hdl/msfc_drive_shaper.sv
hdl/motor_speed_filter_and_controller.sv
dv/motor_speed_filter_and_controller_tb.sv
